[hdl/cbez_pkg.sv]
// cbez_pkg: shared constants and types for the cubic Bezier evaluator.
// No dependencies; imported by every module of the block.
package cbez_pkg;

    localparam int COORD_W    = 32;
    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = $clog2(NUM_REGS);
    localparam int ADDR_W     = REG_IDX_W + 2;
    localparam int NUM_STAGES = 7;
    localparam int CHUNK_W    = 25;

    // pipeline stage positions
    localparam int ST_CLAMP  = 0;
    localparam int ST_SQUARE = 1;
    localparam int ST_WEIGHT = 2;
    localparam int ST_PART   = 3;
    localparam int ST_MERGE  = 4;
    localparam int ST_PAIR   = 5;
    localparam int ST_OUT    = 6;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef enum logic [REG_IDX_W-1:0] {
        REG_P0_X,
        REG_P0_Y,
        REG_P1_X,
        REG_P1_Y,
        REG_P2_X,
        REG_P2_Y,
        REG_P3_X,
        REG_P3_Y
    } reg_idx_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctl_t;

endpackage

[hdl/cubic_bezier_point_eval.sv]
// cubic_bezier_point_eval: cubic Bezier point in Bernstein form; uses cbez_pkg and submodules.
// Pipeline: seven register stages from param transaction to curve_valid.
// Throughput: one transaction per cycle while curve_stall is low; every multiplier stage is fully pipelined.
// Stalls hold each occupied stage; empty stages keep filling, so bubbles collapse.
// Reset: rst_n (async, active low) empties the pipeline and clears all control points to 0.
module cubic_bezier_point_eval #(
    parameter int T_FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // APB configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cbez_pkg::ADDR_W-1:0]         paddr,
    input  logic [cbez_pkg::COORD_W-1:0]        pwdata,
    output logic [cbez_pkg::COORD_W-1:0]        prdata,
    output logic                                pready,
    // parameter input channel
    input  logic                                param_valid,
    output logic                                param_stall,
    input  logic [T_FRAC_BITS:0]                param_t,
    // curve point output channel
    output logic                                curve_valid,
    input  logic                                curve_stall,
    output logic signed [cbez_pkg::COORD_W-1:0] curve_x,
    output logic signed [cbez_pkg::COORD_W-1:0] curve_y
);
    import cbez_pkg::*;

    logic [NUM_STAGES-1:0]     valid_reg, valid_next;
    pipe_ctl_t                 ctl;
    logic signed [COORD_W-1:0] coord   [NUM_REGS];
    logic signed [COORD_W-1:0] coord_x [4];
    logic signed [COORD_W-1:0] coord_y [4];
    logic [3*T_FRAC_BITS:0]    weight  [4];

    // Control points; the user must write them only while no transaction is in flight (not enforced here).
    cbez_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coord   (coord)
    );

    always_comb
    begin
        coord_x[0] = coord[REG_P0_X];
        coord_x[1] = coord[REG_P1_X];
        coord_x[2] = coord[REG_P2_X];
        coord_x[3] = coord[REG_P3_X];
        coord_y[0] = coord[REG_P0_Y];
        coord_y[1] = coord[REG_P1_Y];
        coord_y[2] = coord[REG_P2_Y];
        coord_y[3] = coord[REG_P3_Y];
    end

    // Stage load enables: a stage loads when it is empty or its successor moves.
    // The last stage is the output register, freed when the consumer is not stalling.
    always_comb
    begin : stage_load
        logic downstream_free;
        downstream_free = !curve_stall;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
        begin
            ctl.load[k]     = !valid_reg[k] || downstream_free;
            downstream_free = ctl.load[k];
        end
    end

    // Valid bits travel with the data.
    always_comb
    begin
        valid_next    = valid_reg;
        if (ctl.load[0])
        begin
            valid_next[0] = param_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (ctl.load[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign param_stall = !ctl.load[0];
    assign curve_valid = valid_reg[NUM_STAGES-1];

    // Stages 1-3: clamp t, squares, Bernstein weights (shared by both axes).
    cbez_weights #(
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_weights (
        .clk     (clk),
        .ctl     (ctl),
        .param_t (param_t),
        .weight  (weight)
    );

    // Stages 4-7: products, sums, round, saturate, output register.
    cbez_axis #(
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_axis_x (
        .clk    (clk),
        .ctl    (ctl),
        .weight (weight),
        .coord  (coord_x),
        .result (curve_x)
    );

    cbez_axis #(
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_axis_y (
        .clk    (clk),
        .ctl    (ctl),
        .weight (weight),
        .coord  (coord_y),
        .result (curve_y)
    );

`ifndef NO_ASSERTIONS
    // a free output side never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !curve_stall |-> !param_stall)
    else $error("input stalled while output side is free");

    // a full pipeline behind a stalled output must stall the input
    assert property (@(posedge clk) disable iff (!rst_n)
        (curve_stall && (&valid_reg)) |-> param_stall)
    else $error("full pipeline accepted a transaction");

    // transactions in flight change only by accepts at either end
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(valid_reg) == $past($countones(valid_reg))
                  + int'($past(param_valid && !param_stall))
                  - int'($past(curve_valid && !curve_stall))))
    else $error("transaction lost or duplicated in pipeline");
`endif

endmodule

[hdl/cbez_regs.sv]
// cbez_regs: APB register file holding the four control points.
// Depends on cbez_pkg.
module cbez_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cbez_pkg::ADDR_W-1:0]         paddr,
    input  logic [cbez_pkg::COORD_W-1:0]        pwdata,
    output logic [cbez_pkg::COORD_W-1:0]        prdata,
    output logic                                pready,
    output logic signed [cbez_pkg::COORD_W-1:0] coord [cbez_pkg::NUM_REGS]
);
    import cbez_pkg::*;

    logic signed [COORD_W-1:0] coord_reg  [NUM_REGS];
    logic signed [COORD_W-1:0] coord_next [NUM_REGS];
    logic [REG_IDX_W-1:0]      reg_sel;
    logic                      wr_en;

    assign pready  = 1'b1;
    assign reg_sel = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign prdata  = coord_reg[reg_sel];

    always_comb
    begin
        coord_next = coord_reg;
        if (wr_en)
        begin
            coord_next[reg_sel] = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                coord_reg[i] <= '0;
            end
        end
        else
        begin
            coord_reg <= coord_next;
        end
    end

    assign coord = coord_reg;

endmodule

[hdl/cbez_weights.sv]
// cbez_weights: clamps t and forms the four Bernstein weights in three stages.
// Depends on cbez_pkg.
module cbez_weights #(
    parameter int T_FRAC_BITS = 16
) (
    input  logic                    clk,
    input  cbez_pkg::pipe_ctl_t     ctl,
    input  logic [T_FRAC_BITS:0]    param_t,
    output logic [3*T_FRAC_BITS:0]  weight [4]
);
    import cbez_pkg::*;

    localparam int TW  = T_FRAC_BITS + 1;
    localparam int SQW = 2 * T_FRAC_BITS + 1;
    localparam int T3W = TW + 2;
    localparam int WW  = 3 * T_FRAC_BITS + 1;
    localparam logic [TW-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

    logic [TW-1:0]  t_reg, t_next, u_reg, u_next;
    logic [SQW-1:0] t2_reg, t2_next, u2_reg, u2_next;
    logic [T3W-1:0] t3_reg, t3_next, u3_reg, u3_next;
    logic [TW-1:0]  tq_reg, uq_reg;
    logic [WW-1:0]  weight_reg  [4];
    logic [WW-1:0]  weight_next [4];

    // stage 1: t above one saturates to one
    always_comb
    begin
        t_next = (param_t > T_ONE) ? T_ONE : param_t;
        u_next = T_ONE - t_next;
    end

    // stage 2: squares and 3x terms
    always_comb
    begin
        t2_next = SQW'(t_reg) * SQW'(t_reg);
        u2_next = SQW'(u_reg) * SQW'(u_reg);
        t3_next = (T3W'(t_reg) << 1) + T3W'(t_reg);
        u3_next = (T3W'(u_reg) << 1) + T3W'(u_reg);
    end

    // stage 3: weights scaled by 2^(3*T_FRAC_BITS)
    always_comb
    begin
        weight_next[0] = WW'(u2_reg) * WW'(uq_reg);
        weight_next[1] = WW'(u2_reg) * WW'(t3_reg);
        weight_next[2] = WW'(t2_reg) * WW'(u3_reg);
        weight_next[3] = WW'(t2_reg) * WW'(tq_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[ST_CLAMP])
        begin
            t_reg <= t_next;
            u_reg <= u_next;
        end
        if (ctl.load[ST_SQUARE])
        begin
            t2_reg <= t2_next;
            u2_reg <= u2_next;
            t3_reg <= t3_next;
            u3_reg <= u3_next;
            tq_reg <= t_reg;
            uq_reg <= u_reg;
        end
        if (ctl.load[ST_WEIGHT])
        begin
            weight_reg <= weight_next;
        end
    end

    assign weight = weight_reg;

endmodule

[hdl/cbez_axis.sv]
// cbez_axis: weighted sum of four coordinates, rounding and saturation, four stages.
// Depends on cbez_pkg; one instance per axis.
module cbez_axis #(
    parameter int T_FRAC_BITS = 16
) (
    input  logic                                clk,
    input  cbez_pkg::pipe_ctl_t                 ctl,
    input  logic [3*T_FRAC_BITS:0]              weight [4],
    input  logic signed [cbez_pkg::COORD_W-1:0] coord  [4],
    output logic signed [cbez_pkg::COORD_W-1:0] result
);
    import cbez_pkg::*;

    localparam int WW    = 3 * T_FRAC_BITS + 1;
    localparam int NCH   = (WW + CHUNK_W - 1) / CHUNK_W;
    localparam int XW    = NCH * CHUNK_W;
    localparam int PPW   = CHUNK_W + 1 + COORD_W;
    localparam int PW    = WW + COORD_W;
    localparam int AW    = PW + 2;
    localparam int SHIFT = 3 * T_FRAC_BITS;
    localparam int SW    = AW - SHIFT;
    localparam logic signed [AW-1:0] HALF = AW'(1) << (SHIFT - 1);

    logic signed [PPW-1:0]     pp_reg    [4][NCH];
    logic signed [PPW-1:0]     pp_next   [4][NCH];
    logic signed [PW-1:0]      prod_reg  [4];
    logic signed [PW-1:0]      prod_next [4];
    logic signed [AW-1:0]      pair_reg  [2];
    logic signed [AW-1:0]      pair_next [2];
    logic signed [COORD_W-1:0] result_reg, result_next;

    // partial products: weight cut into CHUNK_W-bit slices
    always_comb
    begin : part_products
        logic [XW-1:0] wext;
        for (int i = 0; i < 4; i++)
        begin
            wext = XW'(weight[i]);
            for (int k = 0; k < NCH; k++)
            begin
                pp_next[i][k] = $signed({1'b0, wext[k*CHUNK_W +: CHUNK_W]}) * coord[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            prod_next[i] = '0;
            for (int k = 0; k < NCH; k++)
            begin
                prod_next[i] = prod_next[i] + (PW'(pp_reg[i][k]) <<< (k * CHUNK_W));
            end
        end
    end

    // rounding half is folded into the second pair
    always_comb
    begin
        pair_next[0] = AW'(prod_reg[0]) + AW'(prod_reg[1]);
        pair_next[1] = AW'(prod_reg[2]) + AW'(prod_reg[3]) + HALF;
    end

    always_comb
    begin : final_sum
        logic signed [AW-1:0] acc;
        logic [SW-1:0]        scaled;
        logic [SW-COORD_W:0]  top;
        acc    = pair_reg[0] + pair_reg[1];
        scaled = acc[AW-1:SHIFT];
        top    = scaled[SW-1:COORD_W-1];
        if ((&top) || !(|top))
        begin
            result_next = scaled[COORD_W-1:0];
        end
        else if (scaled[SW-1])
        begin
            result_next = COORD_MIN;
        end
        else
        begin
            result_next = COORD_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[ST_PART])
        begin
            pp_reg <= pp_next;
        end
        if (ctl.load[ST_MERGE])
        begin
            prod_reg <= prod_next;
        end
        if (ctl.load[ST_PAIR])
        begin
            pair_reg <= pair_next;
        end
        if (ctl.load[ST_OUT])
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule
